@@ src/gtg_pkg.sv @@
// Constants, codes and the arctangent table of the go-to-goal steering controller.
`timescale 1ns / 1ps
package gtg_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int FRAC_BITS    = 16;

    localparam int CW  = 37;
    localparam int PW  = 72;
    localparam int BW  = 33;
    localparam int DW  = FRAC_BITS + 3;
    localparam int ITW = 6;

    localparam logic [29:0] INV_GAIN_Q30 = 30'd652032874;
    localparam logic [31:0] TWO_PI_Q29   = 32'd3373259426;

    localparam logic [2:0] REG_TARGET_X       = 3'd0;
    localparam logic [2:0] REG_TARGET_Y       = 3'd1;
    localparam logic [2:0] REG_CRUISE_SPEED   = 3'd2;
    localparam logic [2:0] REG_HEADING_GAIN   = 3'd3;
    localparam logic [2:0] REG_RATE_DAMPING   = 3'd4;
    localparam logic [2:0] REG_NEAR_GAIN      = 3'd5;
    localparam logic [2:0] REG_FAR_THRESHOLD  = 3'd6;
    localparam logic [2:0] REG_STOP_THRESHOLD = 3'd7;

    localparam logic [1:0] ZONE_FAR     = 2'd0;
    localparam logic [1:0] ZONE_NEAR    = 2'd1;
    localparam logic [1:0] ZONE_ARRIVED = 2'd2;

    localparam logic       OP_POSE = 1'b0;

    function automatic logic [31:0] atan_turn(input logic [4:0] i);
        logic [31:0] r;
        unique case (i)
            5'd0:  r = 32'h20000000;
            5'd1:  r = 32'h12E4051E;
            5'd2:  r = 32'h09FB385B;
            5'd3:  r = 32'h051111D4;
            5'd4:  r = 32'h028B0D43;
            5'd5:  r = 32'h0145D7E1;
            5'd6:  r = 32'h00A2F61E;
            5'd7:  r = 32'h00517C55;
            5'd8:  r = 32'h0028BE53;
            5'd9:  r = 32'h00145F2F;
            5'd10: r = 32'h000A2F98;
            5'd11: r = 32'h000517CC;
            5'd12: r = 32'h00028BE6;
            5'd13: r = 32'h000145F3;
            5'd14: r = 32'h0000A2FA;
            5'd15: r = 32'h0000517D;
            5'd16: r = 32'h000028BE;
            5'd17: r = 32'h0000145F;
            5'd18: r = 32'h00000A30;
            5'd19: r = 32'h00000518;
            5'd20: r = 32'h0000028C;
            5'd21: r = 32'h00000146;
            5'd22: r = 32'h000000A3;
            5'd23: r = 32'h00000051;
            5'd24: r = 32'h00000029;
            5'd25: r = 32'h00000014;
            5'd26: r = 32'h0000000A;
            5'd27: r = 32'h00000005;
            5'd28: r = 32'h00000003;
            5'd29: r = 32'h00000001;
            5'd30: r = 32'h00000001;
            default: r = 32'h00000000;
        endcase
        return r;
    endfunction

endpackage

@@ src/gtg_req_if.sv @@
// Input channel carrying pose updates and control ticks.
`timescale 1ns / 1ps
interface gtg_req_if;
    logic               valid;
    logic               ready;
    logic               op;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
    logic signed [15:0] yaw_rate;
    modport source(output valid, op, pos_x, pos_y, quat_x, quat_y, quat_z, quat_w, yaw_rate,
                   input ready);
    modport sink(input valid, op, pos_x, pos_y, quat_x, quat_y, quat_z, quat_w, yaw_rate,
                 output ready);
endinterface

@@ src/gtg_rsp_if.sv @@
// Output channel carrying speed and turn commands.
`timescale 1ns / 1ps
interface gtg_rsp_if;
    logic               valid;
    logic               ready;
    logic        [30:0] linear_cmd;
    logic signed [31:0] angular_cmd;
    logic        [1:0]  zone;
    modport source(output valid, linear_cmd, angular_cmd, zone, input ready);
    modport sink(input valid, linear_cmd, angular_cmd, zone, output ready);
endinterface

@@ src/gtg_cfg_if.sv @@
// Configuration write channel.
`timescale 1ns / 1ps
interface gtg_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  addr;
    logic [31:0] data;
    modport source(output valid, addr, data, input ready);
    modport sink(input valid, addr, data, output ready);
endinterface

@@ src/go_to_goal_steering_controller_core.sv @@
// Top level of the go-to-goal steering controller with shared CORDIC and serial multiplier.
//
//  channel | direction | payload
//  req     | in        | op, pos_x, pos_y, quat_x..quat_w, yaw_rate
//  rsp     | out       | linear_cmd, angular_cmd, zone
//  cfg     | in        | addr, data
//
// A pose update is stored straight from IDLE; a control tick runs longest when far, shorter when
// near and shortest when arrived, set by the one-bit-per-cycle multiplier and the CORDIC iterations.
// A new item is taken while a finished result still waits on rsp.
// Reset restores the register defaults and clears the held pose; no clearing pass is needed.
// A stalled rsp holds the next result in its final step until the output register frees.
`timescale 1ns / 1ps
module go_to_goal_steering_controller_core (
    input logic  clk,
    input logic  rst_n,
    gtg_req_if.sink   req,
    gtg_rsp_if.source rsp,
    gtg_cfg_if.sink   cfg
);
    import gtg_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CORD = 2'd1;
    localparam logic [1:0] ST_MUL  = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    localparam logic [3:0] PH_VEC  = 4'd0;
    localparam logic [3:0] PH_DIST = 4'd1;
    localparam logic [3:0] PH_QWZ  = 4'd2;
    localparam logic [3:0] PH_QXY  = 4'd3;
    localparam logic [3:0] PH_QYY  = 4'd4;
    localparam logic [3:0] PH_QZZ  = 4'd5;
    localparam logic [3:0] PH_YAW  = 4'd6;
    localparam logic [3:0] PH_ERR  = 4'd7;
    localparam logic [3:0] PH_HG   = 4'd8;
    localparam logic [3:0] PH_RD   = 4'd9;
    localparam logic [3:0] PH_NEAR = 4'd10;

    localparam logic [ITW-1:0] STEPS = ITW'(CORDIC_STEPS);
    localparam logic signed [PW-1:0] ONE_P     = PW'(1);
    localparam logic signed [PW-1:0] DIST_RND  = ONE_P <<< 29;
    localparam logic signed [PW-1:0] ERR_RND   = ONE_P <<< (60 - FRAC_BITS);
    localparam logic signed [PW-1:0] MAX31_P   = PW'(64'sh7FFFFFFF);
    localparam logic signed [PW-1:0] MIN32_P   = PW'(-64'sh80000000);
    localparam logic signed [CW-1:0] CS_BASE   = CW'(64'sd268435456);

    logic [1:0] state_reg, state_next;
    logic [3:0] phase_reg, phase_next;

    logic signed [31:0] tx_reg, tx_next, ty_reg, ty_next;
    logic [19:0] cruise_reg, cruise_next, hgain_reg, hgain_next;
    logic [19:0] damp_reg, damp_next, ngain_reg, ngain_next;
    logic [30:0] far_reg, far_next, stop_reg, stop_next;

    logic signed [31:0] px_reg, px_next, py_reg, py_next;
    logic signed [15:0] qx_reg, qx_next, qy_reg, qy_next, qz_reg, qz_next, qw_reg, qw_next;
    logic signed [15:0] yr_reg, yr_next;
    logic pv_reg, pv_next;

    logic signed [CW-1:0] cx_reg, cx_next, cy_reg, cy_next;
    logic [31:0] cz_reg, cz_next;
    logic [ITW-1:0] it_reg, it_next;

    logic signed [PW-1:0] ma_reg, ma_next, acc_reg, acc_next;
    logic [BW-1:0] mb_reg, mb_next;
    logic [ITW-1:0] mlen_reg, mlen_next, mcnt_reg, mcnt_next;

    logic [31:0] bearing_reg, bearing_next;
    logic [30:0] dist_reg, dist_next;
    logic signed [CW-1:0] sn_reg, sn_next, cs_reg, cs_next;
    logic diffneg_reg, diffneg_next;
    logic signed [PW-1:0] t1_reg, t1_next;

    logic [30:0] rlin_reg, rlin_next;
    logic [31:0] rang_reg, rang_next;
    logic [1:0]  rzone_reg, rzone_next;

    logic [30:0] olin_reg, olin_next;
    logic [31:0] oang_reg, oang_next;
    logic [1:0]  ozone_reg, ozone_next;
    logic ov_reg, ov_next;

    always_comb
    begin
        logic signed [32:0] dx33, dy33;
        logic signed [CW-1:0] lx, ly, xs, ys, cs_fin;
        logic launch_cord;
        logic signed [PW-1:0] addend, rnd, sh, e_full, ang_full;
        logic [31:0] diff, emag;
        logic signed [DW-1:0] e_d;

        state_next = state_reg;   phase_next = phase_reg;
        tx_next = tx_reg;         ty_next = ty_reg;
        cruise_next = cruise_reg; hgain_next = hgain_reg;
        damp_next = damp_reg;     ngain_next = ngain_reg;
        far_next = far_reg;       stop_next = stop_reg;
        px_next = px_reg;         py_next = py_reg;
        qx_next = qx_reg;         qy_next = qy_reg;
        qz_next = qz_reg;         qw_next = qw_reg;
        yr_next = yr_reg;         pv_next = pv_reg;
        cx_next = cx_reg;         cy_next = cy_reg;
        cz_next = cz_reg;         it_next = it_reg;
        ma_next = ma_reg;         mb_next = mb_reg;
        mlen_next = mlen_reg;     mcnt_next = mcnt_reg;
        acc_next = acc_reg;
        bearing_next = bearing_reg; dist_next = dist_reg;
        sn_next = sn_reg;         cs_next = cs_reg;
        diffneg_next = diffneg_reg; t1_next = t1_reg;
        rlin_next = rlin_reg;     rang_next = rang_reg;   rzone_next = rzone_reg;
        olin_next = olin_reg;     oang_next = oang_reg;   ozone_next = ozone_reg;
        ov_next = ov_reg && !rsp.ready;

        dx33 = 33'(tx_reg) - 33'(px_reg);
        dy33 = 33'(ty_reg) - 33'(py_reg);
        cs_fin = CS_BASE - ((cs_reg + CW'(acc_reg)) <<< 1);
        launch_cord = 1'b0;
        lx = '0;
        ly = '0;
        xs = cx_reg >>> it_reg[4:0];
        ys = cy_reg >>> it_reg[4:0];
        addend = (mcnt_reg == mlen_reg - ITW'(1)) ? -ma_reg : ma_reg;
        rnd = acc_reg + DIST_RND;
        sh = rnd >>> 30;
        e_full = (acc_reg + ERR_RND) >>> (61 - FRAC_BITS);
        e_d = diffneg_reg ? -DW'(e_full) : DW'(e_full);
        ang_full = (t1_reg - acc_reg) >>> FRAC_BITS;
        sh = (state_reg == ST_MUL && phase_reg == PH_NEAR) ? (acc_reg >>> FRAC_BITS) : sh;
        diff = bearing_reg - cz_reg;
        emag = diff[31] ? (32'd0 - diff) : diff;

        if (cfg.valid)
        begin
            unique case (cfg.addr)
                REG_TARGET_X:       tx_next = cfg.data;
                REG_TARGET_Y:       ty_next = cfg.data;
                REG_CRUISE_SPEED:   cruise_next = cfg.data[19:0];
                REG_HEADING_GAIN:   hgain_next = cfg.data[19:0];
                REG_RATE_DAMPING:   damp_next = cfg.data[19:0];
                REG_NEAR_GAIN:      ngain_next = cfg.data[19:0];
                REG_FAR_THRESHOLD:  far_next = cfg.data[30:0];
                REG_STOP_THRESHOLD: stop_next = cfg.data[30:0];
                default:            far_next = far_reg;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    if (req.op == OP_POSE)
                    begin
                        px_next = req.pos_x;   py_next = req.pos_y;
                        qx_next = req.quat_x;  qy_next = req.quat_y;
                        qz_next = req.quat_z;  qw_next = req.quat_w;
                        yr_next = req.yaw_rate;
                        pv_next = 1'b1;
                    end
                    else if (pv_reg)
                    begin
                        lx = (dx33[32] != dx33[31]) ? (dx33[32] ? CW'(-64'sh80000000)
                             : CW'(64'sh7FFFFFFF)) : CW'(dx33);
                        ly = (dy33[32] != dy33[31]) ? (dy33[32] ? CW'(-64'sh80000000)
                             : CW'(64'sh7FFFFFFF)) : CW'(dy33);
                        launch_cord = 1'b1;
                        phase_next = PH_VEC;
                    end
                end
            end
            ST_CORD:
            begin
                if (it_reg == STEPS)
                begin
                    if (phase_reg == PH_VEC)
                    begin
                        bearing_next = cz_reg;
                        ma_next = PW'(cx_reg);
                        mb_next = BW'(INV_GAIN_Q30);
                        mlen_next = ITW'(31);
                        mcnt_next = '0;
                        acc_next = '0;
                        phase_next = PH_DIST;
                        state_next = ST_MUL;
                    end
                    else if (dist_reg > far_reg)
                    begin
                        diffneg_next = diff[31] && (diff != 32'h80000000);
                        ma_next = PW'({1'b0, emag});
                        mb_next = BW'(TWO_PI_Q29);
                        mlen_next = ITW'(BW);
                        mcnt_next = '0;
                        acc_next = '0;
                        phase_next = PH_ERR;
                        state_next = ST_MUL;
                    end
                    else if (dist_reg > stop_reg)
                    begin
                        ma_next = PW'({1'b0, dist_reg});
                        mb_next = BW'(ngain_reg);
                        mlen_next = ITW'(21);
                        mcnt_next = '0;
                        acc_next = '0;
                        phase_next = PH_NEAR;
                        state_next = ST_MUL;
                    end
                    else
                    begin
                        rlin_next = '0;
                        rang_next = '0;
                        rzone_next = ZONE_ARRIVED;
                        state_next = ST_OUT;
                    end
                end
                else
                begin
                    if (cy_reg > 0)
                    begin
                        cx_next = cx_reg + ys;
                        cy_next = cy_reg - xs;
                        cz_next = cz_reg + atan_turn(it_reg[4:0]);
                    end
                    else
                    begin
                        cx_next = cx_reg - ys;
                        cy_next = cy_reg + xs;
                        cz_next = cz_reg - atan_turn(it_reg[4:0]);
                    end
                    it_next = it_reg + ITW'(1);
                end
            end
            ST_MUL:
            begin
                if (mcnt_reg != mlen_reg)
                begin
                    if (mb_reg[0])
                    begin
                        acc_next = acc_reg + addend;
                    end
                    ma_next = ma_reg <<< 1;
                    mb_next = mb_reg >> 1;
                    mcnt_next = mcnt_reg + ITW'(1);
                end
                else
                begin
                    mcnt_next = '0;
                    acc_next = '0;
                    mlen_next = ITW'(16);
                    unique case (phase_reg)
                        PH_DIST:
                        begin
                            dist_next = (sh > MAX31_P) ? 31'h7FFFFFFF : sh[30:0];
                            ma_next = PW'(qw_reg);
                            mb_next = BW'(unsigned'(qz_reg));
                            phase_next = PH_QWZ;
                        end
                        PH_QWZ:
                        begin
                            sn_next = CW'(acc_reg);
                            ma_next = PW'(qx_reg);
                            mb_next = BW'(unsigned'(qy_reg));
                            phase_next = PH_QXY;
                        end
                        PH_QXY:
                        begin
                            sn_next = (sn_reg + CW'(acc_reg)) <<< 1;
                            ma_next = PW'(qy_reg);
                            mb_next = BW'(unsigned'(qy_reg));
                            phase_next = PH_QYY;
                        end
                        PH_QYY:
                        begin
                            cs_next = CW'(acc_reg);
                            ma_next = PW'(qz_reg);
                            mb_next = BW'(unsigned'(qz_reg));
                            phase_next = PH_QZZ;
                        end
                        PH_QZZ:
                        begin
                            lx = cs_fin;
                            ly = sn_reg;
                            launch_cord = 1'b1;
                            phase_next = PH_YAW;
                        end
                        PH_ERR:
                        begin
                            ma_next = PW'(e_d);
                            mb_next = BW'(hgain_reg);
                            mlen_next = ITW'(21);
                            phase_next = PH_HG;
                        end
                        PH_HG:
                        begin
                            t1_next = acc_reg;
                            ma_next = PW'(yr_reg) <<< (FRAC_BITS - 12);
                            mb_next = BW'(damp_reg);
                            mlen_next = ITW'(21);
                            phase_next = PH_RD;
                        end
                        PH_RD:
                        begin
                            rang_next = (ang_full > MAX31_P) ? 32'h7FFFFFFF :
                                        (ang_full < MIN32_P) ? 32'h80000000 : ang_full[31:0];
                            rlin_next = 31'(cruise_reg);
                            rzone_next = ZONE_FAR;
                            state_next = ST_OUT;
                        end
                        PH_NEAR:
                        begin
                            rlin_next = (sh > MAX31_P) ? 31'h7FFFFFFF : sh[30:0];
                            rang_next = (sh > MAX31_P) ? 32'h7FFFFFFF : {1'b0, sh[30:0]};
                            rzone_next = ZONE_NEAR;
                            state_next = ST_OUT;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_OUT:
            begin
                if (!ov_reg || rsp.ready)
                begin
                    olin_next = rlin_reg;
                    oang_next = rang_reg;
                    ozone_next = rzone_reg;
                    ov_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (launch_cord)
        begin
            state_next = ST_CORD;
            it_next = '0;
            if (lx == 0 && ly == 0)
            begin
                cx_next = '0;
                cy_next = '0;
                cz_next = '0;
                it_next = STEPS;
            end
            else if (lx < 0 && ly >= 0)
            begin
                cx_next = ly;
                cy_next = -lx;
                cz_next = 32'h40000000;
            end
            else if (lx < 0)
            begin
                cx_next = -ly;
                cy_next = lx;
                cz_next = 32'hC0000000;
            end
            else
            begin
                cx_next = lx;
                cy_next = ly;
                cz_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            phase_reg  <= PH_VEC;
            tx_reg     <= 32'sd327680;
            ty_reg     <= 32'sd327680;
            cruise_reg <= 20'd32768;
            hgain_reg  <= 20'd65536;
            damp_reg   <= 20'd32768;
            ngain_reg  <= 20'd19661;
            far_reg    <= 31'd6554;
            stop_reg   <= 31'd1638;
            px_reg     <= '0;
            py_reg     <= '0;
            qx_reg     <= '0;
            qy_reg     <= '0;
            qz_reg     <= '0;
            qw_reg     <= '0;
            yr_reg     <= '0;
            pv_reg     <= 1'b0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            phase_reg  <= phase_next;
            tx_reg     <= tx_next;
            ty_reg     <= ty_next;
            cruise_reg <= cruise_next;
            hgain_reg  <= hgain_next;
            damp_reg   <= damp_next;
            ngain_reg  <= ngain_next;
            far_reg    <= far_next;
            stop_reg   <= stop_next;
            px_reg     <= px_next;
            py_reg     <= py_next;
            qx_reg     <= qx_next;
            qy_reg     <= qy_next;
            qz_reg     <= qz_next;
            qw_reg     <= qw_next;
            yr_reg     <= yr_next;
            pv_reg     <= pv_next;
            ov_reg     <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cx_reg      <= cx_next;
        cy_reg      <= cy_next;
        cz_reg      <= cz_next;
        it_reg      <= it_next;
        ma_reg      <= ma_next;
        mb_reg      <= mb_next;
        mlen_reg    <= mlen_next;
        mcnt_reg    <= mcnt_next;
        acc_reg     <= acc_next;
        bearing_reg <= bearing_next;
        dist_reg    <= dist_next;
        sn_reg      <= sn_next;
        cs_reg      <= cs_next;
        diffneg_reg <= diffneg_next;
        t1_reg      <= t1_next;
        rlin_reg    <= rlin_next;
        rang_reg    <= rang_next;
        rzone_reg   <= rzone_next;
        olin_reg    <= olin_next;
        oang_reg    <= oang_next;
        ozone_reg   <= ozone_next;
    end

    assign req.ready       = (state_reg == ST_IDLE);
    assign cfg.ready       = 1'b1;
    assign rsp.valid       = ov_reg;
    assign rsp.linear_cmd  = olin_reg;
    assign rsp.angular_cmd = oang_reg;
    assign rsp.zone        = ozone_reg;

endmodule

@@ src/gtg_checker.sv @@
// Port-level assertions for the steering controller and the bind that attaches them.
`timescale 1ns / 1ps
module gtg_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               rsp_valid,
    input logic               rsp_ready,
    input logic        [30:0] linear_cmd,
    input logic signed [31:0] angular_cmd,
    input logic        [1:0]  zone
);
    import gtg_pkg::*;

    a_zone_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (zone == ZONE_FAR || zone == ZONE_NEAR || zone == ZONE_ARRIVED))
        else $error("Result carries an undefined zone code.");

    a_arrived_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && zone == ZONE_ARRIVED |-> linear_cmd == 31'd0 && angular_cmd == 32'sd0)
        else $error("Arrived result has nonzero commands.");

    a_near_equal: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && zone == ZONE_NEAR |-> angular_cmd == $signed({1'b0, linear_cmd}))
        else $error("Near result has unequal speed and turn commands.");

    a_far_cruise: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && zone == ZONE_FAR |-> linear_cmd[30:20] == 11'd0)
        else $error("Far result speed exceeds the cruise register range.");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(linear_cmd)
            && $stable(angular_cmd) && $stable(zone))
        else $error("Stalled result transfer changed.");

endmodule

bind go_to_goal_steering_controller_core gtg_checker u_gtg_checker (
    .clk(clk),
    .rst_n(rst_n),
    .rsp_valid(rsp.valid),
    .rsp_ready(rsp.ready),
    .linear_cmd(rsp.linear_cmd),
    .angular_cmd(rsp.angular_cmd),
    .zone(rsp.zone)
);

@@ dv/gtg_tb_pkg.sv @@
// Predictor of the go-to-goal steering controller used by the testbench.
`timescale 1ns / 1ps
package gtg_tb_pkg;
    import gtg_pkg::*;

    typedef struct packed {
        logic        op;
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [15:0] quat_x;
        logic [15:0] quat_y;
        logic [15:0] quat_z;
        logic [15:0] quat_w;
        logic [15:0] yaw_rate;
    } pose_item_t;

    typedef struct packed {
        logic [30:0] linear_cmd;
        logic [31:0] angular_cmd;
        logic [1:0]  zone;
    } steer_cmd_t;

    localparam logic [31:0] ATAN_TABLE [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
        32'h00000001, 32'h00000000
    };

    function automatic longint sat(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic logic [31:0] rotate_to_angle(longint x, longint y, output longint mag);
        logic [31:0] z;
        longint t, xs, ys;
        z = 0;
        if (x == 0 && y == 0)
        begin
            mag = 0;
            return 0;
        end
        if (x < 0)
        begin
            if (y >= 0)
            begin
                t = x; x = y; y = -t; z = 32'h40000000;
            end
            else
            begin
                t = x; x = -y; y = t; z = 32'hC0000000;
            end
        end
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0)
            begin
                x += ys; y -= xs; z += ATAN_TABLE[i];
            end
            else
            begin
                x -= ys; y += xs; z -= ATAN_TABLE[i];
            end
        end
        mag = x;
        return z;
    endfunction

    function automatic steer_cmd_t steer_command(logic [31:0] regs[8], pose_item_t p);
        steer_cmd_t r;
        longint dx, dy, mag, qx, qy, qz, qw, sn, cs, lin, ang, d;
        longint unsigned distance, emag, e;
        logic [31:0] bearing, yaw, diff;
        dx = sat(longint'($signed(regs[0])) - longint'($signed(p.pos_x)),
                 -64'sd2147483648, 64'sd2147483647);
        dy = sat(longint'($signed(regs[1])) - longint'($signed(p.pos_y)),
                 -64'sd2147483648, 64'sd2147483647);
        bearing = rotate_to_angle(dx, dy, mag);
        distance = (longint'(mag) * 64'd652032874 + (64'd1 << 29)) >> 30;
        if (distance > 64'h7FFFFFFF) distance = 64'h7FFFFFFF;
        qx = $signed(p.quat_x); qy = $signed(p.quat_y);
        qz = $signed(p.quat_z); qw = $signed(p.quat_w);
        sn = 2 * (qw * qz + qx * qy);
        cs = (64'sd1 <<< 28) - 2 * (qy * qy + qz * qz);
        yaw = rotate_to_angle(cs, sn, mag);
        if (distance > regs[6])
        begin
            r.zone = ZONE_FAR;
            diff = bearing - yaw;
            emag = diff[31] ? 64'(32'(0 - diff)) : 64'(diff);
            if (diff == 32'h80000000) emag = 64'h80000000;
            e = (emag * 64'd3373259426 + (64'd1 << (60 - FRAC_BITS))) >> (61 - FRAC_BITS);
            d = e;
            if (diff[31] && diff != 32'h80000000) d = -d;
            ang = longint'(regs[3]) * d
                - longint'(regs[4])
                  * (longint'($signed(p.yaw_rate)) * (64'sd1 <<< (FRAC_BITS - 12)));
            ang = sat(ang >>> FRAC_BITS, -64'sd2147483648, 64'sd2147483647);
            lin = regs[2];
        end
        else if (distance > regs[7])
        begin
            r.zone = ZONE_NEAR;
            lin = (longint'(regs[5]) * distance) >> FRAC_BITS;
            ang = sat(lin, 0, 64'sd2147483647);
            lin = sat(lin, 0, 64'sd2147483647);
        end
        else
        begin
            r.zone = ZONE_ARRIVED;
            lin = 0;
            ang = 0;
        end
        r.linear_cmd = lin[30:0];
        r.angular_cmd = ang[31:0];
        return r;
    endfunction
endpackage

@@ dv/testbench.sv @@
// Self-checking testbench of the go-to-goal steering controller core.
`timescale 1ns / 1ps
module testbench;
    import gtg_pkg::*;
    import gtg_tb_pkg::*;

    localparam int N_RANDOM = 1830;
    localparam int CYCLE_LIMIT = 1500000;

    logic clk;
    logic rst_n;
    gtg_req_if req ();
    gtg_rsp_if rsp ();
    gtg_cfg_if cfg ();

    go_to_goal_steering_controller_core i_dut (
        .clk(clk), .rst_n(rst_n), .req(req.sink), .rsp(rsp.source), .cfg(cfg.sink)
    );

    typedef struct {
        pose_item_t item;
        bit         typed;
        steer_cmd_t cmd;
    } stim_row_t;

    logic [31:0] regs [8];
    logic [31:0] pose_regs [8];
    pose_item_t  held_pose;
    bit          pose_seen;
    steer_cmd_t  pending_cmds [$];
    int          mismatches;
    int          cycles;
    bit          hold_off;
    bit          hold_done;

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic pose_item_t make_item(logic op, logic [31:0] x, logic [31:0] y,
                                             logic [15:0] qz, logic [15:0] qw,
                                             logic [15:0] rate);
        pose_item_t p;
        p = '{op: op, pos_x: x, pos_y: y, quat_x: 0, quat_y: 0, quat_z: qz, quat_w: qw,
              yaw_rate: rate};
        return p;
    endfunction

    function automatic logic [15:0] rand_quat();
        case ($urandom_range(0, 3))
            0: return 16'(16384);
            1: return -16'sd16384;
            2: return 16'($urandom);
            default: return 16'($signed($urandom_range(0, 32768)) - 16384);
        endcase
    endfunction

    function automatic pose_item_t random_item();
        pose_item_t p;
        p.op = ($urandom_range(0, 2) != 0);
        if ($urandom_range(0, 9) == 0)
        begin
            p.pos_x = $urandom;
            p.pos_y = $urandom;
        end
        else
        begin
            p.pos_x = regs[0] + 32'($signed(32'($urandom_range(0, 32'h100000)) - 32'h80000));
            p.pos_y = regs[1] + 32'($signed(32'($urandom_range(0, 32'h100000)) - 32'h80000));
            if ($urandom_range(0, 3) == 0)
            begin
                p.pos_x = regs[0] + 32'($signed(32'($urandom_range(0, 16000)) - 8000));
                p.pos_y = regs[1] + 32'($signed(32'($urandom_range(0, 16000)) - 8000));
            end
        end
        p.quat_x = rand_quat();
        p.quat_y = rand_quat();
        p.quat_z = rand_quat();
        p.quat_w = rand_quat();
        p.yaw_rate = $urandom;
        return p;
    endfunction

    task automatic send_item(pose_item_t p);
        int gap;
        gap = $urandom_range(0, 6);
        if (gap != 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.valid <= 1'b1;
        req.op <= p.op;
        req.pos_x <= p.pos_x;
        req.pos_y <= p.pos_y;
        req.quat_x <= p.quat_x;
        req.quat_y <= p.quat_y;
        req.quat_z <= p.quat_z;
        req.quat_w <= p.quat_w;
        req.yaw_rate <= p.yaw_rate;
        do @(posedge clk); while (!req.ready);
        if (p.op == OP_POSE)
        begin
            held_pose = p;
            pose_seen = 1'b1;
        end
        else if (pose_seen)
        begin
            pending_cmds.push_back(steer_command(regs, held_pose));
        end
    endtask

    task automatic write_reg(logic [2:0] addr, logic [31:0] data);
        cfg.valid <= 1'b1;
        cfg.addr <= addr;
        cfg.data <= data;
        do @(posedge clk); while (!cfg.ready);
        cfg.valid <= 1'b0;
        case (addr)
            REG_TARGET_X, REG_TARGET_Y: regs[addr] = data;
            REG_FAR_THRESHOLD, REG_STOP_THRESHOLD: regs[addr] = data & 32'h7FFFFFFF;
            default: regs[addr] = data & 32'hFFFFF;
        endcase
        @(posedge clk);
    endtask

    task automatic drain();
        req.valid <= 1'b0;
        while (pending_cmds.size() != 0) @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic random_config();
        write_reg(REG_TARGET_X, $urandom);
        write_reg(REG_TARGET_Y, $urandom);
        write_reg(REG_CRUISE_SPEED, $urandom);
        write_reg(REG_HEADING_GAIN, $urandom);
        write_reg(REG_RATE_DAMPING, $urandom);
        write_reg(REG_NEAR_GAIN, $urandom);
        write_reg(REG_FAR_THRESHOLD, $urandom_range(0, 32'h100000));
        write_reg(REG_STOP_THRESHOLD, $urandom_range(0, 32'h20000));
    endtask

    always @(posedge clk)
    begin
        if (hold_off || $urandom_range(0, 3) == 0)
            rsp.ready <= 1'b0;
        else
            rsp.ready <= 1'b1;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (pending_cmds.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected transfer: lin %h ang %h zone %0d",
                             rsp.linear_cmd, rsp.angular_cmd, rsp.zone);
            end
            else
            begin
                if (rsp.linear_cmd !== pending_cmds[0].linear_cmd ||
                    rsp.angular_cmd !== pending_cmds[0].angular_cmd ||
                    rsp.zone !== pending_cmds[0].zone)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch: expected lin %h ang %h zone %0d, got %h %h %0d",
                                 pending_cmds[0].linear_cmd, pending_cmds[0].angular_cmd,
                                 pending_cmds[0].zone, rsp.linear_cmd, rsp.angular_cmd,
                                 rsp.zone);
                end
                void'(pending_cmds.pop_front());
            end
        end
    end

    initial
    begin
        stim_row_t rows [$];
        stim_row_t row;
        steer_cmd_t got;
        int hold_count;
        cycles = 0;
        mismatches = 0;
        pose_seen = 1'b0;
        hold_off = 1'b0;
        rst_n = 1'b0;
        req.valid = 1'b0;
        req.op = 1'b0;
        req.pos_x = 0;
        req.pos_y = 0;
        req.quat_x = 0;
        req.quat_y = 0;
        req.quat_z = 0;
        req.quat_w = 0;
        req.yaw_rate = 0;
        cfg.valid = 1'b0;
        cfg.addr = 0;
        cfg.data = 0;
        rsp.ready = 1'b0;
        regs = '{327680, 327680, 32768, 65536, 32768, 19661, 6554, 1638};
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows: a tick before any pose gives nothing; at the target it arrives.
        rows.push_back('{make_item(1, 0, 0, 0, 16384, 0), 0, '0});
        rows.push_back('{make_item(0, 327680, 327680, 0, 16384, 0), 0, '0});
        rows.push_back('{make_item(1, 0, 0, 0, 0, 0), 1, '{0, 0, ZONE_ARRIVED}});
        rows.push_back('{make_item(0, 327680 - 3000, 327680, 0, 16384, 0), 0, '0});
        rows.push_back('{make_item(1, 0, 0, 0, 0, 0), 0, '0});
        rows.push_back('{make_item(0, 0, 0, 0, 16384, 16'h7FFF), 0, '0});
        rows.push_back('{make_item(1, 0, 0, 0, 0, 0), 0, '0});
        rows.push_back('{make_item(0, 32'h80000000, 32'h80000000, 16384, 0, 16'h8000), 0, '0});
        rows.push_back('{make_item(1, 0, 0, 0, 0, 0), 0, '0});
        rows.push_back('{make_item(0, 32'h7FFFFFFF, 32'h80000000, -16'sd16384, 0, 0), 0, '0});
        rows.push_back('{make_item(1, 0, 0, 0, 0, 0), 0, '0});
        rows.push_back('{make_item(0, 327680 + 65536, 327680, 0, 16384, 0), 0, '0});
        rows.push_back('{make_item(1, 0, 0, 0, 0, 0), 0, '0});
        rows.push_back('{make_item(0, 327680, 327680 - 65536, 0, 0, 16'h1000), 0, '0});
        rows.push_back('{make_item(1, 0, 0, 0, 0, 0), 0, '0});
        foreach (rows[i])
        begin
            row = rows[i];
            send_item(row.item);
            if (row.typed)
            begin
                got = pending_cmds[$];
                if (got !== row.cmd)
                begin
                    mismatches++;
                    $display("Directed row %0d: expected %h, predicted %h", i, row.cmd, got);
                end
            end
        end
        drain();

        write_reg(REG_TARGET_X, 32'h7FFFFFFF);
        write_reg(REG_TARGET_Y, 32'h80000000);
        write_reg(REG_CRUISE_SPEED, 32'hFFFFF);
        write_reg(REG_HEADING_GAIN, 32'hFFFFF);
        write_reg(REG_RATE_DAMPING, 32'hFFFFF);
        write_reg(REG_NEAR_GAIN, 32'hFFFFF);
        write_reg(REG_FAR_THRESHOLD, 32'h7FFFFFFF);
        write_reg(REG_STOP_THRESHOLD, 32'h7FFFFFFF);
        write_reg(REG_STOP_THRESHOLD, 32'hFFFFFFFF);
        send_item(make_item(0, 32'h80000000, 32'h7FFFFFFF, 16384, 16384, 16'h8000));
        send_item(make_item(1, 0, 0, 0, 0, 0));
        drain();
        write_reg(REG_FAR_THRESHOLD, 0);
        write_reg(REG_STOP_THRESHOLD, 0);
        send_item(make_item(1, 0, 0, 0, 0, 0));
        drain();
        write_reg(REG_FAR_THRESHOLD, 32'h7FFFFFFF);
        send_item(make_item(1, 0, 0, 0, 0, 0));
        drain();
        write_reg(REG_TARGET_X, 327680);
        write_reg(REG_TARGET_Y, 327680);
        write_reg(REG_CRUISE_SPEED, 32768);
        write_reg(REG_HEADING_GAIN, 65536);
        write_reg(REG_RATE_DAMPING, 32768);
        write_reg(REG_NEAR_GAIN, 19661);
        write_reg(REG_FAR_THRESHOLD, 6554);
        write_reg(REG_STOP_THRESHOLD, 1638);

        fork
            begin
                @(posedge clk);
                hold_off = 1'b1;
                for (hold_count = 0; hold_count < 2000; hold_count++) @(posedge clk);
                hold_off = 1'b0;
            end
            for (int i = 0; i < 40; i++) send_item(random_item());
        join
        drain();

        for (int i = 0; i < N_RANDOM; i++)
        begin
            if (i % 300 == 299)
            begin
                drain();
                if (i % 600 == 599)
                begin
                    write_reg(REG_TARGET_X, 327680);
                    write_reg(REG_TARGET_Y, 327680);
                    write_reg(REG_FAR_THRESHOLD, 6554);
                    write_reg(REG_STOP_THRESHOLD, 1638);
                end
                else
                    random_config();
            end
            send_item(random_item());
        end
        drain();

        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
